// File: rtl/core/mf3_pkg.sv
// Shared constants, register codes and types for the 3x3 median filter.
// No dependencies; every other file of the block imports this package.
package mf3_pkg;

  localparam int DEF_MAX_WIDTH   = 2048;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int QUEUE_DEPTH = 4;

  localparam int WCFG_BITS = 12;
  localparam int HCFG_BITS = 13;
  localparam int ROW_BITS  = 12;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [WCFG_BITS-1:0] RST_FRAME_WIDTH  = WCFG_BITS'(640);
  localparam logic [HCFG_BITS-1:0] RST_FRAME_HEIGHT = HCFG_BITS'(480);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Which clamped neighborhoods one pixel releases.
  typedef struct packed {
    logic row_up;  // result for the previous row
    logic row_dn;  // result for the current (last) row
    logic col_lf;  // result for the previous column
    logic col_rt;  // result for the current (last) column
  } job_flags_t;

endpackage

// File: rtl/core/mf3_if.sv
// Stream channel interfaces: pixel input and median result output.
// Depends on mf3_pkg for the default sample width.
interface mf3_in_if
  import mf3_pkg::*;
#(parameter int SAMPLE_BITS = DEF_SAMPLE_BITS) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mf3_out_if
  import mf3_pkg::*;
#(parameter int SAMPLE_BITS = DEF_SAMPLE_BITS) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] median_value;
  logic                   run_last;
  logic                   frame_last;

  modport source (output valid, output median_value, output run_last, output frame_last,
                  input ready);
  modport sink   (input valid, input median_value, input run_last, input frame_last,
                  output ready);
endinterface

// File: rtl/core/median_filter_3x3_top.sv
// Top level of the 3x3 median filter: APB register file and the
// front end, job queue and median back end. Uses mf3_pkg and mf3_if.
//
// Accepts one pixel per clock unless the job queue is full. The front end
// reads both line stores at the incoming column as it accepts a pixel and
// updates the window once that pixel can move on; a four-entry queue feeds
// the back end, which, while the output is not stalled, issues one median
// per clock into a three-stage compare pipeline plus output register. A
// pixel releases zero, one or two results, and up to four at the end of the
// last row; the queue buffers them, and the front end stalls when it is full.
// A register write restarts the frame at its first pixel; write
// only while the block is idle. Line stores need no clearing after reset.
module median_filter_3x3_top
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  mf3_in_if.sink                   in_if,
  mf3_out_if.source                out_if,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int JW = 9 * SAMPLE_BITS + $bits(job_flags_t);

  function automatic logic [CB-1:0] width_last(logic [WCFG_BITS-1:0] w);
    if (w == '0) return '0;
    if (32'(w) > MAX_WIDTH) return CB'(MAX_WIDTH - 1);
    return CB'(32'(w) - 1);
  endfunction

  function automatic logic [ROW_BITS-1:0] height_last(logic [HCFG_BITS-1:0] h);
    if (h == '0) return '0;
    if (32'(h) > HEIGHT_LIMIT) return ROW_BITS'(HEIGHT_LIMIT - 1);
    return ROW_BITS'(32'(h) - 1);
  endfunction

  logic [WCFG_BITS-1:0] fw_r;
  logic [HCFG_BITS-1:0] fh_r;
  logic [CB-1:0]        w_last_r;
  logic [ROW_BITS-1:0]  h_last_r;
  logic                 cfg_wr;
  reg_idx_t             widx;

  logic          q_push_valid, q_push_ready, q_pop_valid, q_pop;
  logic [JW-1:0] q_push_data, q_pop_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign widx   = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (widx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_BITS'(fw_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_BITS'(fh_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= RST_FRAME_WIDTH;
      fh_r     <= RST_FRAME_HEIGHT;
      w_last_r <= width_last(RST_FRAME_WIDTH);
      h_last_r <= height_last(RST_FRAME_HEIGHT);
    end else if (cfg_wr) begin
      unique case (widx)
        REG_FRAME_WIDTH: begin
          fw_r     <= pwdata[WCFG_BITS-1:0];
          w_last_r <= width_last(pwdata[WCFG_BITS-1:0]);
        end
        REG_FRAME_HEIGHT: begin
          fh_r     <= pwdata[HCFG_BITS-1:0];
          h_last_r <= height_last(pwdata[HCFG_BITS-1:0]);
        end
        default: ;
      endcase
    end
  end

  mf3_front #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .w_last     (w_last_r),
    .h_last     (h_last_r),
    .in_ch      (in_if),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  mf3_queue #(.JW(JW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop        (q_pop),
    .pop_data   (q_pop_data)
  );

  mf3_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_pop_valid),
    .job_data  (q_pop_data),
    .job_pop   (q_pop),
    .out_ch    (out_if)
  );

endmodule

// File: rtl/core/mf3_front.sv
// Front end: accepts pixels, runs the two line stores and the 3x3 window,
// and pushes a window snapshot with its result flags. Uses mf3_pkg, mf3_if.
module mf3_front
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int CB = $clog2(MAX_WIDTH),
  localparam int JW = 9 * SAMPLE_BITS + $bits(job_flags_t)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                restart,
  input  logic [CB-1:0]       w_last,
  input  logic [ROW_BITS-1:0] h_last,
  mf3_in_if.sink              in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output logic [JW-1:0]       push_data
);

  logic [SAMPLE_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] lower_mem [MAX_WIDTH];

  logic [CB-1:0]          col_r;
  logic [ROW_BITS-1:0]    row_r;
  logic                   b_valid_r;
  logic [SAMPLE_BITS-1:0] b_pix_r;
  logic [CB-1:0]          b_col_r;
  logic                   b_row0_r;
  job_flags_t             b_flags_r;
  logic [SAMPLE_BITS-1:0] rd_up_r, rd_lo_r;
  logic [8:0][SAMPLE_BITS-1:0] win_r, win_nxt;

  logic                   accept, b_fire, has_res, byp;
  logic [SAMPLE_BITS-1:0] top, mid, bot, up_wdata;

  assign has_res    = (b_flags_r.row_up | b_flags_r.row_dn) &
                      (b_flags_r.col_lf | b_flags_r.col_rt);
  assign b_fire     = b_valid_r && (push_ready || !has_res);
  assign in_ch.ready = !b_valid_r || b_fire;
  assign accept     = in_ch.valid && in_ch.ready;
  assign byp        = b_fire && (b_col_r == col_r);

  always_comb begin
    if (b_row0_r) begin
      top = b_pix_r;
      mid = b_pix_r;
      bot = b_pix_r;
    end else begin
      top = rd_up_r;
      mid = rd_lo_r;
      bot = b_pix_r;
    end
    up_wdata = b_row0_r ? b_pix_r : rd_lo_r;
    // window index is column*3 + row; column 2 is newest
    if (!b_flags_r.col_lf) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i*3+0] = top;
        win_nxt[i*3+1] = mid;
        win_nxt[i*3+2] = bot;
      end
    end else begin
      for (int i = 0; i < 6; i++) win_nxt[i] = win_r[i+3];
      win_nxt[6] = top;
      win_nxt[7] = mid;
      win_nxt[8] = bot;
    end
  end

  assign push_valid = b_valid_r && has_res;
  assign push_data  = {win_nxt, b_flags_r};

  always_ff @(posedge clk) begin
    if (b_fire) begin
      upper_mem[b_col_r] <= up_wdata;
      lower_mem[b_col_r] <= b_pix_r;
    end
    if (accept) begin
      // forward a write to the same column that lands in this cycle
      rd_up_r   <= byp ? up_wdata : upper_mem[col_r];
      rd_lo_r   <= byp ? b_pix_r : lower_mem[col_r];
      b_pix_r   <= in_ch.pixel_value;
      b_col_r   <= col_r;
      b_row0_r  <= (row_r == '0);
      b_flags_r <= '{row_up: (row_r != '0), row_dn: (row_r == h_last),
                     col_lf: (col_r != '0), col_rt: (col_r == w_last)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
      win_r     <= '0;
    end else begin
      if (b_fire) win_r <= win_nxt;
      if (accept) b_valid_r <= 1'b1;
      else if (b_fire) b_valid_r <= 1'b0;
      if (restart) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (col_r == w_last) begin
          col_r <= '0;
          row_r <= (row_r == h_last) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/mf3_queue.sv
// Short job queue between the front end and the median back end.
// Uses mf3_pkg for its depth.
module mf3_queue
  import mf3_pkg::*;
#(
  parameter int JW = 148
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [JW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop,
  output logic [JW-1:0] pop_data
);

  localparam int PB = $clog2(QUEUE_DEPTH);

  logic [JW-1:0] slot_r [QUEUE_DEPTH];
  logic [PB-1:0] wr_r, rd_r;
  logic [PB:0]   cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != PB'(0) + (PB+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: rtl/core/mf3_back.sv
// Back end: walks the clamped neighborhoods of each job and finds each
// median in a three-stage compare pipeline. Uses mf3_pkg, mf3_if.
module mf3_back
  import mf3_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int JW = 9 * SAMPLE_BITS + $bits(job_flags_t)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  logic [JW-1:0] job_data,
  output logic          job_pop,
  mf3_out_if.source     out_ch
);

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  function automatic smp_t smin(smp_t a, smp_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic smp_t smax(smp_t a, smp_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic smp_t smed(smp_t a, smp_t b, smp_t c);
    return smax(smin(a, b), smin(smax(a, b), c));
  endfunction

  function automatic logic [1:0] clampi(logic right, logic [1:0] i);
    if (!right) return i;
    return (i == 2'd0) ? 2'd1 : 2'd2;
  endfunction

  logic [8:0][SAMPLE_BITS-1:0] win;
  job_flags_t                  flg;
  logic [3:0]                  mask, avail;
  logic [1:0]                  sel_r, k;
  logic                        more, en, issue;
  logic [8:0][SAMPLE_BITS-1:0] nine;

  logic                        s0_v_r, s1_v_r, s2_v_r;
  logic [8:0][SAMPLE_BITS-1:0] s0_r, s1_r;
  logic [2:0][SAMPLE_BITS-1:0] s2_r;
  logic [1:0]                  s0_t_r, s1_t_r, s2_t_r;  // {run_last, frame_last}
  logic                        out_v_r;
  smp_t                        out_d_r;
  logic [1:0]                  out_t_r;

  assign {win, flg} = job_data;
  assign mask = {flg.row_dn & flg.col_rt, flg.row_dn & flg.col_lf,
                 flg.row_up & flg.col_rt, flg.row_up & flg.col_lf};
  assign avail = mask & (4'b1111 << sel_r);

  always_comb begin
    k = 2'd3;
    for (int i = 3; i >= 0; i--) if (avail[i]) k = 2'(i);
    more = |(avail & ~(4'b1111 >> (3 - k)));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        nine[i*3+j] = win[clampi(k[0], 2'(i))*3 + clampi(k[1], 2'(j))];
  end

  assign en      = !out_v_r || out_ch.ready;
  assign issue   = job_valid && en;
  assign job_pop = issue && !more;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r   <= nine;
      s0_t_r <= {!more, (k == 2'd3)};
      for (int t = 0; t < 3; t++) begin
        s1_r[t*3+0] <= smin(smin(s0_r[t*3], s0_r[t*3+1]), s0_r[t*3+2]);
        s1_r[t*3+1] <= smed(s0_r[t*3], s0_r[t*3+1], s0_r[t*3+2]);
        s1_r[t*3+2] <= smax(smax(s0_r[t*3], s0_r[t*3+1]), s0_r[t*3+2]);
      end
      s1_t_r <= s0_t_r;
      s2_r[0] <= smax(smax(s1_r[0], s1_r[3]), s1_r[6]);
      s2_r[1] <= smed(s1_r[1], s1_r[4], s1_r[7]);
      s2_r[2] <= smin(smin(s1_r[2], s1_r[5]), s1_r[8]);
      s2_t_r <= s1_t_r;
      out_d_r <= smed(s2_r[0], s2_r[1], s2_r[2]);
      out_t_r <= s2_t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r  <= issue;
      s1_v_r  <= s0_v_r;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
      if (issue) sel_r <= more ? k + 1'b1 : 2'd0;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.median_value = out_d_r;
  assign out_ch.run_last     = out_t_r[1];
  assign out_ch.frame_last   = out_t_r[0];

endmodule

// File: sim/testbench.sv
// Self-checking testbench for median_filter_3x3_top: pixel frames in, medians out.
// Depends on mf3_pkg and the mf3_in_if / mf3_out_if interfaces of the RTL.
module testbench
  import mf3_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] median_value;
    logic        run_last;
    logic        frame_last;
  } median_res_t;

  typedef struct {
    int unsigned width_cfg;
    int unsigned height_cfg;
    logic [15:0] pixel;
    bit          typed;
    logic [15:0] typed_median;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  mf3_in_if  pix_ch ();
  mf3_out_if med_ch ();

  median_filter_3x3_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(pix_ch.sink), .out_if(med_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the filter state
  logic [15:0] upper_row [2048];
  logic [15:0] lower_row [2048];
  logic [15:0] win [9];
  int unsigned col_cnt, row_cnt;
  logic [WCFG_BITS-1:0] width_reg = RST_FRAME_WIDTH;
  logic [HCFG_BITS-1:0] height_reg = RST_FRAME_HEIGHT;

  median_res_t pending_medians [$];
  int errors = 0;
  int pixels_sent = 0, medians_seen = 0, frames_run = 0;
  bit steady = 1'b0;
  bit hold_sink = 1'b0;

  initial begin
    pix_ch.valid = 1'b0;
    pix_ch.pixel_value = '0;
    med_ch.ready = 1'b0;
    foreach (win[i]) win[i] = '0;
  end

  function automatic logic [15:0] median9(input logic [15:0] v [9]);
    logic [15:0] s [9];
    logic [15:0] t;
    s = v;
    for (int i = 0; i < 9; i++)
      for (int j = 0; j < 8 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j]; s[j] = s[j+1]; s[j+1] = t;
        end
    return s[4];
  endfunction

  function automatic int sel3(input int which, input int i);
    return (which == 0) ? i : ((i == 0) ? 1 : 2);
  endfunction

  function automatic void filter_pixel(input logic [15:0] p, output median_res_t res [$]);
    int unsigned w, h, c, r;
    logic [15:0] top, mid, bot;
    int rows [$];
    int cols [$];
    logic [15:0] nine [9];
    median_res_t m;
    res = {};
    w = (width_reg == 0) ? 1 : ((width_reg > 2048) ? 2048 : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    r = (row_cnt >= h) ? h - 1 : row_cnt;
    if (r == 0) begin
      top = p; mid = p; bot = p;
      upper_row[c] = p;
    end else begin
      top = upper_row[c]; mid = lower_row[c]; bot = p;
      upper_row[c] = mid;
    end
    lower_row[c] = p;
    if (c == 0) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3] = top; win[i*3+1] = mid; win[i*3+2] = bot;
      end
    end else begin
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top; win[7] = mid; win[8] = bot;
    end
    if (r >= 1) rows.push_back(0);
    if (r == h - 1) rows.push_back(1);
    if (c >= 1) cols.push_back(0);
    if (c == w - 1) cols.push_back(1);
    foreach (rows[a])
      foreach (cols[b]) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            nine[i*3+j] = win[sel3(cols[b], i)*3 + sel3(rows[a], j)];
        m.median_value = median9(nine);
        m.run_last = 1'b0;
        m.frame_last = (rows[a] == 1 && cols[b] == 1);
        res.push_back(m);
      end
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    if (c == w - 1) begin
      col_cnt = 0;
      row_cnt = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endfunction

  function automatic int gap_len();
    int k;
    if (steady) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Result sink: ready decided at the falling edge, transfers checked at the rising edge
  always @(negedge clk) begin
    if (hold_sink) begin
      med_ch.ready <= 1'b0;
      repeat (120) @(negedge clk);
      hold_sink = 1'b0;
    end else if (steady) begin
      med_ch.ready <= 1'b1;
    end else begin
      med_ch.ready <= (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    median_res_t e;
    if (rst_n && med_ch.valid && med_ch.ready) begin
      medians_seen++;
      if (pending_medians.size() == 0) begin
        $error("median_value: expected none, got %h", med_ch.median_value);
        errors++;
      end else begin
        e = pending_medians.pop_front();
        if (med_ch.median_value !== e.median_value) begin
          $error("median_value: expected %h, got %h", e.median_value, med_ch.median_value);
          errors++;
        end
        if (med_ch.run_last !== e.run_last) begin
          $error("run_last: expected %b, got %b", e.run_last, med_ch.run_last);
          errors++;
        end
        if (med_ch.frame_last !== e.frame_last) begin
          $error("frame_last: expected %b, got %b", e.frame_last, med_ch.frame_last);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(input logic [15:0] p, input bit typed = 0,
                            input logic [15:0] typed_median = '0);
    median_res_t res [$];
    median_res_t t;
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk) pix_ch.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_ch.valid <= 1'b1;
    pix_ch.pixel_value <= p;
    do @(posedge clk); while (!pix_ch.ready);
    filter_pixel(p, res);
    if (typed) begin
      t.median_value = typed_median; t.run_last = 1'b1; t.frame_last = 1'b1;
      pending_medians.push_back(t);
    end else begin
      foreach (res[i]) pending_medians.push_back(res[i]);
    end
    pixels_sent++;
  endtask

  task automatic drain();
    @(negedge clk) pix_ch.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input reg_idx_t idx, inout logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= wr;
    paddr <= CFG_ADDR_BITS'(4 * int'(idx)); pwdata <= data;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr) data = prdata;
    @(negedge clk) begin
      psel <= 1'b0; penable <= 1'b0;
    end
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    logic [31:0] d;
    drain();
    d = w; apb_access(1, REG_FRAME_WIDTH, d);
    d = h; apb_access(1, REG_FRAME_HEIGHT, d);
    width_reg = WCFG_BITS'(w); height_reg = HCFG_BITS'(h);
    col_cnt = 0; row_cnt = 0;
    d = '0; apb_access(0, REG_FRAME_WIDTH, d);
    if (d[WCFG_BITS-1:0] !== width_reg) begin
      $error("frame_width readback: expected %0d, got %0d", width_reg, d[WCFG_BITS-1:0]);
      errors++;
    end
    d = '0; apb_access(0, REG_FRAME_HEIGHT, d);
    if (d[HCFG_BITS-1:0] !== height_reg) begin
      $error("frame_height readback: expected %0d, got %0d", height_reg, d[HCFG_BITS-1:0]);
      errors++;
    end
    frames_run++;
  endtask

  pixel_row_t directed [] = '{
    '{1, 1, 16'h0000, 1, 16'h0000},
    '{1, 1, 16'hFFFF, 1, 16'hFFFF},
    '{1, 1, 16'h5555, 1, 16'h5555},
    '{1, 1, 16'hAAAA, 1, 16'hAAAA},
    '{0, 0, 16'h1234, 1, 16'h1234},
    '{0, 0, 16'hFEDC, 1, 16'hFEDC},
    '{3, 3, 16'h0000, 0, 0}, '{3, 3, 16'hFFFF, 0, 0}, '{3, 3, 16'h0001, 0, 0},
    '{3, 3, 16'h8000, 0, 0}, '{3, 3, 16'h7FFF, 0, 0}, '{3, 3, 16'hFFFE, 0, 0},
    '{3, 3, 16'h0000, 0, 0}, '{3, 3, 16'hFFFF, 0, 0}, '{3, 3, 16'h00FF, 0, 0},
    '{2, 2, 16'hFFFF, 0, 0}, '{2, 2, 16'h0000, 0, 0},
    '{2, 2, 16'h0000, 0, 0}, '{2, 2, 16'hFFFF, 0, 0},
    '{2, 1, 16'h4321, 0, 0}, '{2, 1, 16'hC001, 0, 0}
  };

  initial begin
    int unsigned cur_w, cur_h, w, h, n, stop_at, style, rnd_items;
    logic [15:0] p;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    cur_w = 9999; cur_h = 9999;

    foreach (directed[i]) begin
      // Restart the frame whenever a row asks for another size
      if (directed[i].width_cfg != cur_w || directed[i].height_cfg != cur_h) begin
        cur_w = directed[i].width_cfg; cur_h = directed[i].height_cfg;
        set_frame(cur_w, cur_h);
      end
      send_pixel(directed[i].pixel, directed[i].typed, directed[i].typed_median);
    end

    // Oversize width clamps to 2048: the start of one long row
    set_frame(4095, 1);
    steady = 1'b1;
    for (int i = 0; i < 16; i++) send_pixel(16'($urandom));
    steady = 1'b0;

    // Oversize height clamps to 4096: a tall, narrow partial frame
    set_frame(1, 8191);
    for (int i = 0; i < 8; i++) send_pixel(16'($urandom));
    set_frame(2048, 4096);
    for (int i = 0; i < 4; i++) send_pixel(16'($urandom));

    rnd_items = 0;
    while (rnd_items < 100) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      set_frame(w, h);
      n = w * h;
      // Some frames are cut short and the next write restarts them
      stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : n;
      if (stop_at > 100 - rnd_items) stop_at = 100 - rnd_items;
      style = $urandom_range(0, 2);
      if (frames_run % 7 == 3) begin
        steady = 1'b1;
        hold_sink = 1'b1;
      end
      for (int i = 0; i < stop_at; i++) begin
        case (style)
          0: p = 16'($urandom);
          1: p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: p = 16'($urandom_range(0, 7));
        endcase
        send_pixel(p);
        rnd_items++;
      end
      steady = 1'b0;
      if (frames_run % 5 == 0) drain();
    end

    drain();
    $display("Sent %0d pixels over %0d frame settings, checked %0d medians.",
             pixels_sent, frames_run, medians_seen);
    $display("Covered 1x1 and clamped sizes, border replication and output stalls.");
    if (errors == 0 && pending_medians.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_medians.size() != 0)
        $error("%0d medians never arrived", pending_medians.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40ms;
    $error("timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
rtl/core/mf3_pkg.sv
rtl/core/mf3_if.sv
rtl/core/mf3_front.sv
rtl/core/mf3_queue.sv
rtl/core/mf3_back.sv
rtl/core/median_filter_3x3_top.sv
sim/testbench.sv
